// ===== rtl/core/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and constants for the time partition scheduler: table sizes,
// command and status codes, and the partition table entry and write port.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int MAX_PARTITIONS = 8;
    localparam int SLICE_BITS     = 16;

    localparam int IDX_W  = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1);
    localparam int CORE_W = 3;

    // port field widths
    localparam int CMD_W      = 2;
    localparam int SLEN_W     = 16;
    localparam int ACT_W      = 3;
    localparam int TICKS_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL        = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NO_PART     = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NOT_STARTED = 2'd3;

    // register index taken from paddr[2]
    localparam logic REG_THIS_CORE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [CORE_W-1:0]     core;
        logic [SLICE_BITS-1:0] slice;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_tbl_wr;

endpackage

// ===== rtl/core/time_partition_scheduler.sv =====
// ----------------------------------------------------------------------------
// time_partition_scheduler
// Round-robin time-slice scheduler over a table of partitions, each with a
// slice length and an owner core.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An add, an unused command, a tick that
// only counts down, or a rejected tick does not scan: its result passes
// through the output state into the output register. A start, or a tick
// that ends a slice, scans the partition table one entry per cycle through
// the single table read port. The next item is taken once the result is in
// the output register, even while that result still waits to be taken.
// this_core is written through the APB port at any address with paddr[2] low.
// ----------------------------------------------------------------------------
module time_partition_scheduler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [tps_pkg::CMD_W-1:0]      i_cmd,
    input  logic [tps_pkg::SLEN_W-1:0]     i_slice_length,
    input  logic [tps_pkg::CORE_W-1:0]     i_owner_core,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [tps_pkg::ACT_W-1:0]      o_active_index,
    output logic                           o_switched,
    output logic                           o_refilled,
    output logic [tps_pkg::TICKS_W-1:0]    o_ticks_left,
    output logic [tps_pkg::STATUS_W-1:0]   o_status,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tps_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import tps_pkg::*;

    t_state r_state, n_state;

    logic [CORE_W-1:0]     r_this_core;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_cur, n_cur;
    logic                  r_running, n_running;
    logic [SLICE_BITS-1:0] r_slice, n_slice;

    // scan control
    logic                  r_is_start, n_is_start;
    logic [CNT_W-1:0]      r_left, n_left;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]      r_rd_tag, n_rd_tag;

    // pending result
    logic                  r_res_sw, n_res_sw;
    logic                  r_res_rf, n_res_rf;
    logic [STATUS_W-1:0]   r_res_sts, n_res_sts;

    // output register
    logic                  r_out_valid;
    logic [ACT_W-1:0]      r_out_act;
    logic                  r_out_sw;
    logic                  r_out_rf;
    logic [TICKS_W-1:0]    r_out_ticks;
    logic [STATUS_W-1:0]   r_out_sts;

    t_tbl_wr               tbl_wr;
    logic                  rd_en;
    t_entry                rd_data;

    logic                  accept;
    logic                  go_scan;
    logic                  match;
    logic                  scan_end;
    logic                  out_load;
    logic                  cfg_wr;
    logic [IDX_W-1:0]      idx_wrap;
    logic [IDX_W-1:0]      cur_wrap;
    logic [SLICE_BITS-1:0] reload;

    tps_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_THIS_CORE);
    assign prdata = (paddr[2] == REG_THIS_CORE) ? APB_DATA_W'(r_this_core) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_this_core <= '0;
        end else if (cfg_wr) begin
            r_this_core <= pwdata[CORE_W-1:0];
        end
    end

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && (r_state == ST_IDLE);
    assign go_scan  = (i_cmd == CMD_START)
                   || ((i_cmd == CMD_TICK) && r_running && (r_slice == '0));
    assign match    = r_rd_vld && (rd_data.core == r_this_core);
    assign scan_end = match || (r_left == '0);
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || !i_stall);
    assign idx_wrap = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count)
                    ? '0 : IDX_W'(CNT_W'(r_idx) + CNT_W'(1));
    assign cur_wrap = ((CNT_W'(r_cur) + CNT_W'(1)) == r_count)
                    ? '0 : IDX_W'(CNT_W'(r_cur) + CNT_W'(1));
    assign reload   = (rd_data.slice == '0) ? '0 : rd_data.slice - SLICE_BITS'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = go_scan ? ST_SCAN : ST_OUT;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and table access
    always_comb begin
        n_count    = r_count;
        n_cur      = r_cur;
        n_running  = r_running;
        n_slice    = r_slice;
        n_is_start = r_is_start;
        n_left     = r_left;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_rd_tag   = r_idx;
        n_res_sw   = r_res_sw;
        n_res_rf   = r_res_rf;
        n_res_sts  = r_res_sts;
        tbl_wr     = '0;
        rd_en      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res_sw  = 1'b0;
                    n_res_rf  = 1'b0;
                    n_res_sts = STS_OK;
                    n_left    = r_count;
                    case (i_cmd)
                        CMD_ADD: begin
                            if (r_count == CNT_W'(MAX_PARTITIONS)) begin
                                n_res_sts = STS_FULL;
                            end else begin
                                tbl_wr.en         = 1'b1;
                                tbl_wr.addr       = IDX_W'(r_count);
                                tbl_wr.data.core  = i_owner_core;
                                tbl_wr.data.slice = SLICE_BITS'(i_slice_length);
                                n_count           = r_count + CNT_W'(1);
                            end
                        end
                        CMD_START: begin
                            n_is_start = 1'b1;
                            n_idx      = '0;
                        end
                        CMD_TICK: begin
                            n_is_start = 1'b0;
                            n_idx      = cur_wrap;
                            if (!r_running) begin
                                n_res_sts = STS_NOT_STARTED;
                            end else if (r_slice != '0) begin
                                n_slice = r_slice - SLICE_BITS'(1);
                            end
                        end
                        default: begin
                            n_res_sts = STS_OK;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (match) begin
                    n_res_sw  = r_is_start ? (!r_running || (r_rd_tag != r_cur))
                                           : (r_rd_tag != r_cur);
                    n_res_rf  = 1'b1;
                    n_res_sts = STS_OK;
                    n_cur     = r_rd_tag;
                    n_slice   = reload;
                    n_running = 1'b1;
                    n_left    = '0;
                end else if (scan_end) begin
                    n_res_sts = STS_NO_PART;
                end else if (r_left != '0) begin
                    rd_en    = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_tag = r_idx;
                    n_idx    = idx_wrap;
                    n_left   = r_left - CNT_W'(1);
                end
            end
            ST_OUT: begin
                n_rd_vld = 1'b0;
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_cur      <= '0;
            r_running  <= 1'b0;
            r_slice    <= '0;
            r_is_start <= 1'b0;
            r_left     <= '0;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_cur      <= n_cur;
            r_running  <= n_running;
            r_slice    <= n_slice;
            r_is_start <= n_is_start;
            r_left     <= n_left;
            r_idx      <= n_idx;
            r_rd_vld   <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_tag  <= n_rd_tag;
        r_res_sw  <= n_res_sw;
        r_res_rf  <= n_res_rf;
        r_res_sts <= n_res_sts;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_act   <= ACT_W'(r_cur);
            r_out_sw    <= r_res_sw;
            r_out_rf    <= r_res_rf;
            r_out_ticks <= TICKS_W'(r_slice);
            r_out_sts   <= r_res_sts;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_active_index = r_out_act;
    assign o_switched     = r_out_sw;
    assign o_refilled     = r_out_rf;
    assign o_ticks_left   = r_out_ticks;
    assign o_status       = r_out_sts;

endmodule

// ===== rtl/core/tps_table.sv =====
// ----------------------------------------------------------------------------
// tps_table
// Partition table: one synchronous memory holding owner core and slice
// length per entry, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tps_table (
    input  logic                  i_clk,
    input  tps_pkg::t_tbl_wr      i_wr,
    input  logic                  i_rd_en,
    input  logic [tps_pkg::IDX_W-1:0] i_rd_addr,
    output tps_pkg::t_entry       o_rd_data
);
    import tps_pkg::*;

    t_entry r_mem [MAX_PARTITIONS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
